### rtl/core/rbsi_pkg.sv
// rbsi_pkg: shared types and constants for the ray/box slab intersect block
// beat payload structs, per-stage divider record and q16.16 saturation limits
// no dependencies
package rbsi_pkg;

  localparam int DW    = 32;
  localparam int N_DIV = 32;

  localparam logic signed [DW-1:0] Q_MAX = 32'sh7fff_ffff;
  localparam logic signed [DW-1:0] Q_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic signed [DW-1:0] box_min_x;
    logic signed [DW-1:0] box_min_y;
    logic signed [DW-1:0] box_min_z;
    logic signed [DW-1:0] box_max_x;
    logic signed [DW-1:0] box_max_y;
    logic signed [DW-1:0] box_max_z;
    logic signed [DW-1:0] ray_origin_x;
    logic signed [DW-1:0] ray_origin_y;
    logic signed [DW-1:0] ray_origin_z;
    logic signed [DW-1:0] ray_dir_x;
    logic signed [DW-1:0] ray_dir_y;
    logic signed [DW-1:0] ray_dir_z;
  } rbsi_in_t;

  typedef struct packed {
    logic                 hit;
    logic signed [DW-1:0] t_enter;
    logic signed [DW-1:0] t_exit;
  } rbsi_out_t;

  // one stage of the restoring divider
  typedef struct packed {
    logic [DW-1:0] rem;
    logic [DW-1:0] lo;
    logic [DW-1:0] quo;
    logic [DW-1:0] dmag;
    logic          qneg;
    logic          ovf;
    logic          dz;
    logic          nneg;
    logic          nzero;
  } rbsi_div_t;

endpackage

### rtl/core/ray_box_slab_intersect.sv
// Ray versus axis-aligned box slab test in signed fixed point. A new beat is taken every
// cycle while no result beat is stalled; a prep stage feeds six parallel divider lanes
// of 32 one-bit restoring stages, then a saturate and two merge stages follow. The
// whole pipeline holds while a result beat is stalled, so in_stall follows out_stall then.
module ray_box_slab_intersect import rbsi_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  rbsi_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output rbsi_out_t out_data
);

  localparam int LAT = N_DIV + 4;

  logic                 en;
  logic [LAT-1:0]       vld_r;
  logic signed [DW-1:0] corner_min [3];
  logic signed [DW-1:0] corner_max [3];
  logic signed [DW-1:0] origin [3];
  logic signed [DW-1:0] dir [3];
  logic signed [DW-1:0] d_min [3];
  logic signed [DW-1:0] d_max [3];

  assign en       = !(vld_r[LAT-1] && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  assign corner_min = '{in_data.box_min_x, in_data.box_min_y, in_data.box_min_z};
  assign corner_max = '{in_data.box_max_x, in_data.box_max_y, in_data.box_max_z};
  assign origin     = '{in_data.ray_origin_x, in_data.ray_origin_y, in_data.ray_origin_z};
  assign dir        = '{in_data.ray_dir_x, in_data.ray_dir_y, in_data.ray_dir_z};

  for (genvar i = 0; i < 3; i++) begin : g_axis
    rbsi_slab_lane #(.FRAC_BITS(FRAC_BITS), .IS_UPPER(1'b0)) u_lane_min (
      .clk        (clk),
      .en         (en),
      .corner     (corner_min[i]),
      .origin     (origin[i]),
      .dir        (dir[i]),
      .plane_dist (d_min[i])
    );
    rbsi_slab_lane #(.FRAC_BITS(FRAC_BITS), .IS_UPPER(1'b1)) u_lane_max (
      .clk        (clk),
      .en         (en),
      .corner     (corner_max[i]),
      .origin     (origin[i]),
      .dir        (dir[i]),
      .plane_dist (d_max[i])
    );
  end

  rbsi_merge #(.FRAC_BITS(FRAC_BITS)) u_merge (
    .clk   (clk),
    .en    (en),
    .d_min (d_min),
    .d_max (d_max),
    .res   (out_data)
  );

  assign out_valid = vld_r[LAT-1];

endmodule

### rtl/core/rbsi_slab_lane.sv
// rbsi_slab_lane: distance to one slab plane, (corner - origin) << frac / dir
// pipelined restoring divider, one quotient bit per stage, saturating result
// depends on rbsi_pkg
module rbsi_slab_lane import rbsi_pkg::*; #(
  parameter int FRAC_BITS = 16,
  parameter bit IS_UPPER  = 1'b0
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [DW-1:0] corner,
  input  logic signed [DW-1:0] origin,
  input  logic signed [DW-1:0] dir,
  output logic signed [DW-1:0] plane_dist
);

  localparam int NW = DW + 1 + FRAC_BITS;
  localparam int HW = NW - DW;

  logic signed [DW:0] num;
  logic [DW:0]        nmag;
  logic [DW-1:0]      dmag;
  logic [NW-1:0]      nshift;
  logic [DW-1:0]      hi_ext;
  rbsi_div_t          prep;

  always_comb begin
    num    = {corner[DW-1], corner} - {origin[DW-1], origin};
    nmag   = num[DW] ? (DW+1)'(-num) : num;
    dmag   = dir[DW-1] ? DW'(-dir) : dir;
    nshift = {nmag, {FRAC_BITS{1'b0}}};
    hi_ext = {{(DW-HW){1'b0}}, nshift[NW-1:DW]};
    prep.rem   = hi_ext;
    prep.lo    = nshift[DW-1:0];
    prep.quo   = '0;
    prep.dmag  = dmag;
    prep.qneg  = num[DW] ^ dir[DW-1];
    prep.ovf   = hi_ext >= dmag;
    prep.dz    = dmag == '0;
    prep.nneg  = num[DW];
    prep.nzero = num == '0;
  end

  rbsi_div_t   stage_r [N_DIV+1];
  rbsi_div_t   stage_nxt [N_DIV];
  logic [DW:0] r2;
  logic [DW:0] diff;

  always_comb begin
    for (int s = 0; s < N_DIV; s++) begin
      r2           = {stage_r[s].rem, stage_r[s].lo[DW-1]};
      diff         = r2 - {1'b0, stage_r[s].dmag};
      stage_nxt[s] = stage_r[s];
      stage_nxt[s].lo = {stage_r[s].lo[DW-2:0], 1'b0};
      if (!diff[DW]) begin
        stage_nxt[s].rem = diff[DW-1:0];
        stage_nxt[s].quo = {stage_r[s].quo[DW-2:0], 1'b1};
      end else begin
        stage_nxt[s].rem = r2[DW-1:0];
        stage_nxt[s].quo = {stage_r[s].quo[DW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stage_r[0] <= prep;
      for (int s = 0; s < N_DIV; s++) stage_r[s+1] <= stage_nxt[s];
    end
  end

  rbsi_div_t          fin;
  logic signed [DW-1:0] dist_nxt;
  logic signed [DW-1:0] dist_r;

  always_comb begin
    fin = stage_r[N_DIV];
    if (fin.dz) begin
      // origin on the plane counts as inside the slab
      if (fin.nzero) dist_nxt = IS_UPPER ? Q_MAX : Q_MIN;
      else           dist_nxt = fin.nneg ? Q_MIN : Q_MAX;
    end else if (fin.ovf) begin
      dist_nxt = fin.qneg ? Q_MIN : Q_MAX;
    end else if (!fin.qneg) begin
      dist_nxt = fin.quo[DW-1] ? Q_MAX : fin.quo;
    end else begin
      dist_nxt = (fin.quo > {1'b1, {(DW-1){1'b0}}}) ? Q_MIN : DW'(-fin.quo);
    end
  end

  always_ff @(posedge clk) begin
    if (en) dist_r <= dist_nxt;
  end

  assign plane_dist = dist_r;

endmodule

### rtl/core/rbsi_merge.sv
// rbsi_merge: orders each slab's distances and intersects x, y, z intervals
// two register stages; the second holds the final result beat
// depends on rbsi_pkg
module rbsi_merge import rbsi_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [DW-1:0] d_min [3],
  input  logic signed [DW-1:0] d_max [3],
  output rbsi_out_t            res
);

  localparam logic [DW-1:0] ONE_Q = DW'(1) << FRAC_BITS;

  logic signed [DW-1:0] a [3];
  logic signed [DW-1:0] b [3];
  logic                 miss1_nxt;
  logic signed [DW-1:0] lo1_nxt, hi1_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (d_min[i] > d_max[i]) begin
        a[i] = d_max[i];
        b[i] = d_min[i];
      end else begin
        a[i] = d_min[i];
        b[i] = d_max[i];
      end
    end
    miss1_nxt = (a[0] > b[1]) || (a[1] > b[0]);
    lo1_nxt   = (a[1] > a[0]) ? a[1] : a[0];
    hi1_nxt   = (b[1] < b[0]) ? b[1] : b[0];
  end

  logic                 miss1_r;
  logic signed [DW-1:0] lo1_r, hi1_r, az_r, bz_r;

  always_ff @(posedge clk) begin
    if (en) begin
      miss1_r <= miss1_nxt;
      lo1_r   <= lo1_nxt;
      hi1_r   <= hi1_nxt;
      az_r    <= a[2];
      bz_r    <= b[2];
    end
  end

  rbsi_out_t res_nxt, res_r;

  always_comb begin
    if (miss1_r || (lo1_r > bz_r) || (az_r > hi1_r)) begin
      res_nxt.hit     = 1'b0;
      res_nxt.t_enter = ONE_Q;
      res_nxt.t_exit  = '0;
    end else begin
      res_nxt.hit     = 1'b1;
      res_nxt.t_enter = (az_r > lo1_r) ? az_r : lo1_r;
      res_nxt.t_exit  = (bz_r < hi1_r) ? bz_r : hi1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) res_r <= res_nxt;
  end

  assign res = res_r;

endmodule

### rtl/core/rbsi_checker.sv
// rbsi_checker: port-level assertions for ray_box_slab_intersect
// bound to the top level below; depends on rbsi_pkg
module rbsi_checker import rbsi_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input logic      clk,
  input logic      rst_n,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input rbsi_out_t out_data
);

  localparam logic [DW-1:0] ONE_Q = DW'(1) << FRAC_BITS;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow a stalled result beat");

  a_miss_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.hit |-> out_data.t_enter == ONE_Q && out_data.t_exit == '0)
    else $error("miss beat carries wrong distances");

  a_hit_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.hit |-> out_data.t_enter <= out_data.t_exit)
    else $error("hit beat with entry beyond exit");

endmodule

bind ray_box_slab_intersect rbsi_checker #(.FRAC_BITS(FRAC_BITS)) u_rbsi_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

### sim/ray_box_slab_intersect_tb.sv
// ray_box_slab_intersect_tb: self-checking bench for the fixed-point ray/box slab test
// drives boxes and rays through a valid/stall channel and checks hit, entry and exit
// depends on rbsi_pkg and ray_box_slab_intersect
`timescale 1ns / 1ps

module ray_box_slab_intersect_tb;
  import rbsi_pkg::*;

  localparam int FRAC = 16;
  localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC;
  localparam int LATENCY = 36;
  localparam int N_RANDOM = 1150;
  localparam longint CYCLE_LIMIT = 2000000;

  typedef struct {
    rbsi_in_t  ray_box;
    bit        typed;
    rbsi_out_t want;
  } test_row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  rbsi_in_t  in_data;
  logic      out_valid;
  logic      out_stall;
  rbsi_out_t out_data;

  rbsi_out_t expected_hits[$];
  int        error_count;
  int        beats_sent;
  int        beats_checked;
  int        hit_count;
  longint    cycle_count;
  int        send_idle_pct;
  int        recv_idle_pct;
  bit        hold_recv;
  bit        done;

  ray_box_slab_intersect #(.FRAC_BITS(FRAC)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint slab_dist(logic signed [31:0] corner,
                                       logic signed [31:0] origin,
                                       logic signed [31:0] dir, bit is_upper);
    longint num;
    longint q;
    num = longint'(corner) - longint'(origin);
    if (dir == 0) begin
      if (num > 0) return 64'sd2147483647;
      if (num < 0) return -64'sd2147483648;
      return is_upper ? 64'sd2147483647 : -64'sd2147483648;
    end
    q = (num * (64'sd1 <<< FRAC)) / longint'(dir);
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return q;
  endfunction

  function automatic rbsi_out_t predict_slab_hit(rbsi_in_t r);
    logic signed [31:0] mn[3];
    logic signed [31:0] mx[3];
    logic signed [31:0] org[3];
    logic signed [31:0] dr[3];
    longint a, b, t, lo, hi;
    rbsi_out_t res;
    mn = '{r.box_min_x, r.box_min_y, r.box_min_z};
    mx = '{r.box_max_x, r.box_max_y, r.box_max_z};
    org = '{r.ray_origin_x, r.ray_origin_y, r.ray_origin_z};
    dr = '{r.ray_dir_x, r.ray_dir_y, r.ray_dir_z};
    lo = 0;
    hi = 0;
    for (int ax = 0; ax < 3; ax++) begin
      a = slab_dist(mn[ax], org[ax], dr[ax], 1'b0);
      b = slab_dist(mx[ax], org[ax], dr[ax], 1'b1);
      if (a > b) begin
        t = a; a = b; b = t;
      end
      if (ax == 0) begin
        lo = a; hi = b;
      end else begin
        // slabs disjoint: give up with the miss encoding
        if (lo > b || a > hi) begin
          res.hit = 1'b0; res.t_enter = ONE; res.t_exit = '0;
          return res;
        end
        if (a > lo) lo = a;
        if (b < hi) hi = b;
      end
    end
    res.hit = 1'b1;
    res.t_enter = lo[31:0];
    res.t_exit = hi[31:0];
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch at beat %0d: %s got %0d want %0d", beats_checked, what, got, want);
    error_count++;
  endtask

  function automatic logic signed [31:0] fx(int units);
    return 32'(units <<< FRAC);
  endfunction

  function automatic rbsi_in_t make_ray(int mnx, int mny, int mnz, int mxx, int mxy, int mxz,
                                        int ox, int oy, int oz, int dx, int dy, int dz);
    rbsi_in_t r;
    r.box_min_x = fx(mnx); r.box_min_y = fx(mny); r.box_min_z = fx(mnz);
    r.box_max_x = fx(mxx); r.box_max_y = fx(mxy); r.box_max_z = fx(mxz);
    r.ray_origin_x = fx(ox); r.ray_origin_y = fx(oy); r.ray_origin_z = fx(oz);
    r.ray_dir_x = fx(dx); r.ray_dir_y = fx(dy); r.ray_dir_z = fx(dz);
    return r;
  endfunction

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return Q_MAX;
      1: return Q_MIN;
      2: return '0;
      3: return $urandom();
      4: return 32'($urandom_range(0, 65535)) - 32'sd32768;
      default: return (32'($urandom_range(0, 200)) - 32'sd100) <<< FRAC
                      | (32'($urandom()) & 32'hffff);
    endcase
  endfunction

  function automatic logic signed [31:0] rand_dir();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return Q_MAX;
      2: return Q_MIN;
      3: return $urandom();
      4: return 32'($urandom_range(0, 15)) - 32'sd8;
      default: return (32'($urandom_range(0, 8)) - 32'sd4) <<< FRAC
                      | (32'($urandom()) & 32'hffff);
    endcase
  endfunction

  // mostly centred boxes, half with the origin placed before the box in x, so the later axes are reached
  function automatic rbsi_in_t rand_ray();
    rbsi_in_t r;
    logic signed [31:0] c[3];
    logic signed [31:0] h[3];
    if ($urandom_range(0, 3) == 0) begin
      r = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
           $urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
      r.ray_dir_x = rand_dir(); r.box_min_y = rand_coord(); r.ray_origin_z = rand_coord();
      return r;
    end
    for (int i = 0; i < 3; i++) begin
      c[i] = (32'($urandom_range(0, 64)) - 32'sd32) <<< FRAC;
      h[i] = 32'($urandom_range(0, 8 << FRAC));
    end
    r.box_min_x = c[0] - h[0]; r.box_max_x = c[0] + h[0];
    r.box_min_y = c[1] - h[1]; r.box_max_y = c[1] + h[1];
    r.box_min_z = c[2] - h[2]; r.box_max_z = c[2] + h[2];
    if ($urandom_range(0, 7) == 0) r.box_min_y = r.box_max_y + ONE;
    r.ray_origin_x = rand_coord(); r.ray_origin_y = rand_coord(); r.ray_origin_z = rand_coord();
    if ($urandom_range(0, 1)) begin
      r.ray_origin_x = c[0] - (32'($urandom_range(4, 40)) <<< FRAC);
      r.ray_origin_y = c[1] + ((32'($urandom_range(0, 8)) - 32'sd4) <<< FRAC);
      r.ray_origin_z = c[2] + ((32'($urandom_range(0, 8)) - 32'sd4) <<< FRAC);
    end
    r.ray_dir_x = rand_dir(); r.ray_dir_y = rand_dir(); r.ray_dir_z = rand_dir();
    return r;
  endfunction

  task automatic send_beat(rbsi_in_t r);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(0, 99) < send_idle_pct) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    expected_hits.push_back(predict_slab_hit(r));
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (expected_hits.size() != 0) @(negedge clk);
  endtask

  // receiver stall, with an optional long hold-off set through hold_recv
  always @(negedge clk) begin
    if (hold_recv) out_stall <= 1'b1;
    else out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_hits.size() == 0) begin
        report_mismatch("unexpected beat, hit", out_data.hit, -1);
      end else begin
        rbsi_out_t want;
        want = expected_hits.pop_front();
        if (out_data.hit !== want.hit) report_mismatch("hit", out_data.hit, want.hit);
        if (out_data.t_enter !== want.t_enter)
          report_mismatch("t_enter", out_data.t_enter, want.t_enter);
        if (out_data.t_exit !== want.t_exit)
          report_mismatch("t_exit", out_data.t_exit, want.t_exit);
        if (want.hit) hit_count++;
      end
      beats_checked++;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT && !done) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_hits.size());
      $display("ray_box_slab_intersect_tb: errors");
      $finish;
    end
  end

  test_row_t directed[$];

  initial begin
    test_row_t row;
    rbsi_in_t r;
    int hold_cycles;
    rst_n = 1'b0; in_valid = 1'b0; in_data = '0; out_stall = 1'b0;
    hold_recv = 1'b0; done = 1'b0; error_count = 0; cycle_count = 0;
    beats_sent = 0; beats_checked = 0; hit_count = 0;
    send_idle_pct = 27; recv_idle_pct = 70;

    // box from 1 to 3 in x hit head-on along x
    row.ray_box = make_ray(1, -1, -1, 3, 1, 1, 0, 0, 0, 1, 0, 0);
    row.typed = 1'b0; directed.push_back(row);
    // disjoint in y: miss encoding
    row.ray_box = make_ray(1, 5, -1, 3, 6, 1, 0, 0, 0, 1, 0, 0);
    row.typed = 1'b1; row.want = '{hit: 1'b0, t_enter: ONE, t_exit: '0};
    directed.push_back(row);
    // disjoint in z
    row.ray_box = make_ray(1, -1, 5, 3, 1, 6, 0, 0, 0, 1, 0, 0);
    directed.push_back(row);
    // inverted box, negative directions, touching slabs, on-plane origin
    row.typed = 1'b0;
    row.ray_box = make_ray(3, 1, 1, 1, -1, -1, 0, 0, 0, 1, 0, 0); directed.push_back(row);
    row.ray_box = make_ray(-3, -1, -1, -1, 1, 1, 0, 0, 0, -1, 0, 0); directed.push_back(row);
    row.ray_box = make_ray(1, 1, -1, 2, 2, 1, 0, 0, 0, 1, 1, 0); directed.push_back(row);
    row.ray_box = make_ray(0, 0, 0, 2, 2, 2, 0, 0, 0, 0, 0, 0); directed.push_back(row);
    row.ray_box = make_ray(-2, -2, -2, 0, 0, 0, 0, 0, 0, 0, 0, 0); directed.push_back(row);
    row.ray_box = make_ray(1, 1, 1, 2, 2, 2, 0, 0, 0, 0, 1, 1); directed.push_back(row);
    row.ray_box = make_ray(-1, 1, 1, 2, 2, 2, 0, 0, 0, 1, 1, 2); directed.push_back(row);
    // all-zero beat: every slab unbounded, full range hit
    row.typed = 1'b1; row.ray_box = '0;
    row.want = '{hit: 1'b1, t_enter: Q_MIN, t_exit: Q_MAX}; directed.push_back(row);
    // field extremes, saturation and tiny directions
    row.typed = 1'b0;
    r = '0; r.box_min_x = Q_MIN; r.box_max_x = Q_MAX; r.ray_dir_x = 32'sd1;
    row.ray_box = r; directed.push_back(row);
    r.ray_origin_x = Q_MAX; r.ray_dir_x = -32'sd1; row.ray_box = r; directed.push_back(row);
    r.ray_origin_x = Q_MIN; r.ray_dir_x = Q_MIN; row.ray_box = r; directed.push_back(row);
    r.ray_dir_x = Q_MAX; r.ray_dir_y = Q_MIN; r.ray_dir_z = 32'sd1; row.ray_box = r;
    directed.push_back(row);
    row.ray_box = {12{Q_MAX}}; directed.push_back(row);
    row.ray_box = {12{Q_MIN}}; directed.push_back(row);
    row.ray_box = {12{32'shffff_ffff}}; directed.push_back(row);
    row.ray_box = {12{32'sh5555_5555}}; directed.push_back(row);
    row.ray_box = {12{32'shaaaa_aaaa}}; directed.push_back(row);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed[i]) begin
      if (directed[i].typed && predict_slab_hit(directed[i].ray_box) != directed[i].want)
        report_mismatch("typed row disagrees with predictor", i, -1);
      send_beat(directed[i].ray_box);
    end

    // back-pressure: receiver holds while the sender keeps offering
    send_idle_pct = 0;
    hold_recv = 1'b1;
    fork
      begin
        hold_cycles = 0;
        while (hold_cycles < 3 * LATENCY) begin
          @(negedge clk);
          hold_cycles++;
        end
        hold_recv = 1'b0;
      end
      repeat (80) send_beat(rand_ray());
    join
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 27 : (ph == 1) ? 70 : 0;
      recv_idle_pct = (ph == 0) ? 70 : (ph == 1) ? 27 : 0;
      repeat (N_RANDOM / 3) send_beat(rand_ray());
      // sender pause until all results are back
      if (ph == 1) drain();
    end

    drain();
    repeat (LATENCY + 4) @(negedge clk);
    done = 1'b1;
    $display("sent %0d ray/box tests, checked %0d results, %0d hits", beats_sent,
             beats_checked, hit_count);
    $display("covered zero directions, saturation, inverted boxes and long back-pressure");
    if (error_count == 0 && expected_hits.size() == 0) begin
      $display("ray_box_slab_intersect_tb: clean");
    end else begin
      $display("ray_box_slab_intersect_tb: errors");
    end
    $finish;
  end

endmodule

### ray_box_slab_intersect.f
rtl/core/rbsi_pkg.sv
rtl/core/rbsi_slab_lane.sv
rtl/core/rbsi_merge.sv
rtl/core/ray_box_slab_intersect.sv
rtl/core/rbsi_checker.sv
sim/ray_box_slab_intersect_tb.sv
